// ===== hw/rtl/bmpcga_pkg.sv =====
package bmpcga_pkg;

  localparam int FRAME_BYTES = 16384;

  localparam int PIX_W  = 8;
  localparam int ADDR_W = 14;
  localparam int DATA_W = 8;
  localparam int SIZE_W = 7;
  localparam int POS_W  = 8;
  localparam int HELD_W = 4;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [ADDR_W-1:0] HALF_BASE = ADDR_W'(FRAME_BYTES / 2);

  typedef enum logic [1:0] {
    REG_WIDTH_QUADS  = 2'd0,
    REG_HEIGHT_PAIRS = 2'd1,
    REG_TOP_DOWN     = 2'd2
  } reg_index_t;

endpackage

// ===== hw/rtl/bmpcga_if.sv =====
interface bmpcga_pix_if;
  logic                        valid;
  logic                        ready;
  logic [bmpcga_pkg::PIX_W-1:0] pixel_pair;
  logic                        image_start;

  modport source (output valid, output pixel_pair, output image_start, input ready);
  modport sink   (input valid, input pixel_pair, input image_start, output ready);
endinterface

interface bmpcga_wr_if;
  logic                          valid;
  logic                          ready;
  logic [bmpcga_pkg::ADDR_W-1:0] write_address;
  logic [bmpcga_pkg::DATA_W-1:0] write_data;
  logic                          last_of_image;

  modport source (output valid, output write_address, output write_data,
                  output last_of_image, input ready);
  modport sink   (input valid, input write_address, input write_data,
                  input last_of_image, output ready);
endinterface

// ===== hw/rtl/bmp4_to_cga_interlaced_packer.sv =====
// Converts the pixel bytes of a 4-bit indexed bitmap, in file order, into byte writes
// for a 16 KB interlaced 2-bit-per-pixel frame. Every second data byte of a row yields one
// transfer carrying the frame address, four packed pixels and a last-of-image flag; row
// padding up to the 4-byte stride is consumed silently, and bytes after the final row are
// dropped until the next byte marked image_start. One input byte is taken per clock cycle
// unless the output stalls: all counter, packing and address work (a 7x7 multiply and two
// adds) sits between the input handshake and a single output register, and a new byte is
// accepted while that register drains. Sizes and row order are set through the APB port
// and should only be changed while the block is idle.
module bmp4_to_cga_interlaced_packer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bmpcga_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [bmpcga_pkg::APB_DATA_W-1:0] pwdata,
  output logic [bmpcga_pkg::APB_DATA_W-1:0] prdata,
  output logic                              pready,
  bmpcga_pix_if.sink                        pix_in,
  bmpcga_wr_if.source                       wr_out
);
  import bmpcga_pkg::*;

  logic [SIZE_W-1:0] width_quads;
  logic [SIZE_W-1:0] height_pairs;
  logic              top_down;

  logic [POS_W-1:0]  byte_in_row;
  logic [POS_W-1:0]  file_row;
  logic [HELD_W-1:0] held_pixels;

  logic [POS_W-1:0]  byte_in_row_next;
  logic [POS_W-1:0]  file_row_next;
  logic [HELD_W-1:0] held_pixels_next;

  logic              out_valid;
  logic [ADDR_W-1:0] out_address;
  logic [DATA_W-1:0] out_data;
  logic              out_last;

  reg_index_t        reg_sel;
  logic              reg_write;
  logic              accept;

  logic [SIZE_W-1:0] w_eff;
  logic [SIZE_W-1:0] hp_eff;
  logic [POS_W-1:0]  rows;
  logic [POS_W-1:0]  data_bytes;
  logic [POS_W:0]    stride;
  logic [POS_W-1:0]  cur_byte;
  logic [POS_W-1:0]  cur_row;
  logic [HELD_W-1:0] cur_held;
  logic              active;
  logic              in_data;
  logic              emit;
  logic [HELD_W-1:0] low_bits;
  logic [SIZE_W-1:0] quad_x;
  logic [POS_W-1:0]  img_row;
  logic [ADDR_W-1:0] row_offset;
  logic [ADDR_W-1:0] calc_address;
  logic [POS_W:0]    byte_inc;

  assign pready    = 1'b1;
  assign reg_sel   = reg_index_t'(paddr[3:2]);
  assign reg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_quads  <= SIZE_W'(80);
      height_pairs <= SIZE_W'(100);
      top_down     <= 1'b0;
    end else if (reg_write) begin
      case (reg_sel)
        REG_WIDTH_QUADS:  width_quads  <= pwdata[SIZE_W-1:0];
        REG_HEIGHT_PAIRS: height_pairs <= pwdata[SIZE_W-1:0];
        REG_TOP_DOWN:     top_down     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_WIDTH_QUADS:  prdata = APB_DATA_W'(width_quads);
      REG_HEIGHT_PAIRS: prdata = APB_DATA_W'(height_pairs);
      REG_TOP_DOWN:     prdata = APB_DATA_W'(top_down);
      default:          prdata = '0;
    endcase
  end

  assign pix_in.ready = !out_valid || wr_out.ready;
  assign accept       = pix_in.valid && pix_in.ready;

  always_comb begin
    w_eff      = (width_quads == '0) ? SIZE_W'(1) : width_quads;
    hp_eff     = (height_pairs == '0) ? SIZE_W'(1) : height_pairs;
    rows       = {hp_eff, 1'b0};
    data_bytes = {w_eff, 1'b0};
    stride     = ({1'b0, data_bytes} + (POS_W+1)'(3)) & ~(POS_W+1)'(3);

    cur_byte = pix_in.image_start ? '0 : byte_in_row;
    cur_row  = pix_in.image_start ? '0 : file_row;
    cur_held = pix_in.image_start ? '0 : held_pixels;

    active   = cur_row < rows;
    in_data  = active && (cur_byte < data_bytes);
    emit     = in_data && cur_byte[0];
    low_bits = {pix_in.pixel_pair[5:4], pix_in.pixel_pair[1:0]};

    quad_x       = cur_byte[POS_W-1:1];
    img_row      = top_down ? cur_row : (rows - POS_W'(1) - cur_row);
    row_offset   = ADDR_W'(img_row[POS_W-1:1]) * ADDR_W'(w_eff);
    calc_address = (img_row[0] ? HALF_BASE : '0) + row_offset + ADDR_W'(quad_x);

    held_pixels_next = (in_data && !cur_byte[0]) ? low_bits : cur_held;
    byte_inc         = {1'b0, cur_byte} + (POS_W+1)'(1);
    byte_in_row_next = cur_byte;
    file_row_next    = cur_row;
    if (active) begin
      if (byte_inc >= stride) begin
        byte_in_row_next = '0;
        file_row_next    = cur_row + POS_W'(1);
      end else begin
        byte_in_row_next = byte_inc[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_in_row <= '0;
      file_row    <= '0;
      held_pixels <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (accept) begin
        byte_in_row <= byte_in_row_next;
        file_row    <= file_row_next;
        held_pixels <= held_pixels_next;
        out_valid   <= emit;
      end else if (wr_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_address <= calc_address;
      out_data    <= {cur_held, low_bits};
      out_last    <= (cur_row == rows - POS_W'(1)) && (quad_x == w_eff - SIZE_W'(1));
    end
  end

  assign wr_out.valid         = out_valid;
  assign wr_out.write_address = out_address;
  assign wr_out.write_data    = out_data;
  assign wr_out.last_of_image = out_last;

endmodule

// ===== hw/rtl/bmpcga_checker.sv =====
module bmpcga_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [bmpcga_pkg::ADDR_W-1:0] out_address,
  input logic [bmpcga_pkg::DATA_W-1:0] out_data,
  input logic                          out_last
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      $stable(out_address) && $stable(out_data) && $stable(out_last))
    else $error("stalled result changed");

  // With the output register empty the block must take input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // A new result only follows an input transfer.
  a_result_from_input: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) && !(in_valid && in_ready) |=> !out_valid)
    else $error("result appeared without an input transfer");

endmodule

bind bmp4_to_cga_interlaced_packer bmpcga_checker u_bmpcga_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (pix_in.valid),
  .in_ready    (pix_in.ready),
  .out_valid   (wr_out.valid),
  .out_ready   (wr_out.ready),
  .out_address (wr_out.write_address),
  .out_data    (wr_out.write_data),
  .out_last    (wr_out.last_of_image)
);

// ===== dv/tb_bmp4_to_cga_interlaced_packer.sv =====
module tb_bmp4_to_cga_interlaced_packer;
  timeunit 1ns;
  timeprecision 1ps;

  import bmpcga_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 4;
  localparam int LONG_HOLD    = 300;
  localparam int RANDOM_BYTES = 1600;
  localparam int MAX_GAP      = 13;
  localparam int N_STEPS      = 35;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic              last;
  } frame_write_t;

  typedef enum bit {
    STEP_BYTE = 1'b0,
    STEP_REG  = 1'b1
  } step_kind_t;

  typedef struct packed {
    step_kind_t        kind;
    reg_index_t        idx;
    logic [SIZE_W-1:0] value;
    logic [PIX_W-1:0]  pix;
    bit                start;
    bit                literal;
    frame_write_t      wr;
  } directed_step_t;

  localparam frame_write_t NO_WR = '0;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  bmpcga_pix_if pix_if ();
  bmpcga_wr_if  wr_if ();

  bmp4_to_cga_interlaced_packer u_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pix_in  (pix_if.sink),
    .wr_out  (wr_if.source)
  );

  logic [SIZE_W-1:0] width_cfg    = 7'd80;
  logic [SIZE_W-1:0] height_cfg   = 7'd100;
  logic              top_down_cfg = 1'b0;
  logic [POS_W-1:0]  byte_pos     = '0;
  logic [POS_W-1:0]  row_pos      = '0;
  logic [HELD_W-1:0] held_pix     = '0;

  frame_write_t pending_writes[$];
  int           errors = 0;
  int           cycles = 0;
  bit           hold_armed = 1'b0;
  bit           rx_steady = 1'b0;
  bit           tx_steady = 1'b0;

  directed_step_t directed_steps [N_STEPS] = '{
    '{STEP_BYTE, REG_WIDTH_QUADS, 7'd0, 8'hFF, 1'b1, 1'b0, NO_WR},
    '{STEP_BYTE, REG_WIDTH_QUADS, 7'd0, 8'h00, 1'b0, 1'b1, '{14'd16112, 8'hF0, 1'b0}},
    '{STEP_BYTE, REG_WIDTH_QUADS, 7'd0, 8'h5A, 1'b0, 1'b0, NO_WR},
    '{STEP_BYTE, REG_WIDTH_QUADS, 7'd0, 8'hC3, 1'b0, 1'b1, '{14'd16113, 8'h63, 1'b0}},
    '{STEP_REG, REG_WIDTH_QUADS, 7'd0, 8'h00, 1'b0, 1'b0, NO_WR},
    '{STEP_REG, REG_HEIGHT_PAIRS, 7'd0, 8'h00, 1'b0, 1'b0, NO_WR},
    '{STEP_REG, REG_TOP_DOWN, 7'd1, 8'h00, 1'b0, 1'b0, NO_WR},
    '{STEP_BYTE, REG_WIDTH_QUADS, 7'd0, 8'hAB, 1'b1, 1'b0, NO_WR},
    '{STEP_BYTE, REG_WIDTH_QUADS, 7'd0, 8'h12, 1'b0, 1'b1, '{14'd0, 8'hB6, 1'b0}},
    '{STEP_BYTE, REG_WIDTH_QUADS, 7'd0, 8'hFF, 1'b0, 1'b0, NO_WR},
    '{STEP_BYTE, REG_WIDTH_QUADS, 7'd0, 8'hFF, 1'b0, 1'b0, NO_WR},
    '{STEP_BYTE, REG_WIDTH_QUADS, 7'd0, 8'h33, 1'b0, 1'b0, NO_WR},
    '{STEP_BYTE, REG_WIDTH_QUADS, 7'd0, 8'h33, 1'b0, 1'b1, '{14'd8192, 8'hFF, 1'b1}},
    '{STEP_BYTE, REG_WIDTH_QUADS, 7'd0, 8'h0F, 1'b0, 1'b0, NO_WR},
    '{STEP_BYTE, REG_WIDTH_QUADS, 7'd0, 8'hF0, 1'b0, 1'b0, NO_WR},
    '{STEP_BYTE, REG_WIDTH_QUADS, 7'd0, 8'h77, 1'b0, 1'b0, NO_WR},
    '{STEP_BYTE, REG_WIDTH_QUADS, 7'd0, 8'h00, 1'b0, 1'b0, NO_WR},
    '{STEP_REG, REG_WIDTH_QUADS, 7'd127, 8'h00, 1'b0, 1'b0, NO_WR},
    '{STEP_REG, REG_HEIGHT_PAIRS, 7'd127, 8'h00, 1'b0, 1'b0, NO_WR},
    '{STEP_REG, REG_TOP_DOWN, 7'd0, 8'h00, 1'b0, 1'b0, NO_WR},
    '{STEP_BYTE, REG_WIDTH_QUADS, 7'd0, 8'h01, 1'b1, 1'b0, NO_WR},
    '{STEP_BYTE, REG_WIDTH_QUADS, 7'd0, 8'h10, 1'b0, 1'b1, '{14'd7810, 8'h14, 1'b0}},
    '{STEP_REG, REG_WIDTH_QUADS, 7'd3, 8'h00, 1'b0, 1'b0, NO_WR},
    '{STEP_BYTE, REG_WIDTH_QUADS, 7'd0, 8'h96, 1'b0, 1'b0, NO_WR},
    '{STEP_BYTE, REG_WIDTH_QUADS, 7'd0, 8'h69, 1'b0, 1'b0, NO_WR},
    '{STEP_BYTE, REG_WIDTH_QUADS, 7'd0, 8'hE7, 1'b0, 1'b0, NO_WR},
    '{STEP_BYTE, REG_WIDTH_QUADS, 7'd0, 8'h7E, 1'b0, 1'b0, NO_WR},
    '{STEP_BYTE, REG_WIDTH_QUADS, 7'd0, 8'h00, 1'b0, 1'b0, NO_WR},
    '{STEP_BYTE, REG_WIDTH_QUADS, 7'd0, 8'hFF, 1'b0, 1'b0, NO_WR},
    '{STEP_BYTE, REG_WIDTH_QUADS, 7'd0, 8'h3C, 1'b0, 1'b0, NO_WR},
    '{STEP_REG, REG_WIDTH_QUADS, 7'd80, 8'h00, 1'b0, 1'b0, NO_WR},
    '{STEP_REG, REG_HEIGHT_PAIRS, 7'd100, 8'h00, 1'b0, 1'b0, NO_WR},
    '{STEP_REG, REG_TOP_DOWN, 7'd1, 8'h00, 1'b0, 1'b0, NO_WR},
    '{STEP_BYTE, REG_WIDTH_QUADS, 7'd0, 8'h55, 1'b1, 1'b0, NO_WR},
    '{STEP_BYTE, REG_WIDTH_QUADS, 7'd0, 8'hAA, 1'b0, 1'b0, NO_WR}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_bmp4_to_cga_interlaced_packer: errors");
      $finish;
    end
  end

  // Updates the position state for one accepted byte and returns 1 when the byte
  // completes a quad, with the frame write it produces.
  function automatic bit predict_write(input logic [PIX_W-1:0] pix, input bit start,
                                       output frame_write_t wr, output bit taken);
    int unsigned w;
    int unsigned rows;
    int unsigned data_bytes;
    int unsigned stride;
    int unsigned x;
    int unsigned y;
    int unsigned addr;
    logic [HELD_W-1:0] lowbits;
    bit has_wr;
    w          = (width_cfg == 0) ? 1 : width_cfg;
    rows       = 2 * ((height_cfg == 0) ? 1 : height_cfg);
    data_bytes = 2 * w;
    stride     = (data_bytes + 3) & 32'hFFFF_FFFC;
    lowbits    = {pix[5:4], pix[1:0]};
    has_wr     = 1'b0;
    wr         = '0;
    if (start) begin
      byte_pos = '0;
      row_pos  = '0;
      held_pix = '0;
    end
    taken = (row_pos < rows);
    if (!taken) return 1'b0;
    if (byte_pos < data_bytes) begin
      if (!byte_pos[0]) begin
        held_pix = lowbits;
      end else begin
        x       = byte_pos >> 1;
        y       = top_down_cfg ? row_pos : (rows - 1 - row_pos);
        addr    = (y[0] ? FRAME_BYTES / 2 : 0) + (y >> 1) * w + x;
        wr.addr = addr[ADDR_W-1:0];
        wr.data = {held_pix, lowbits};
        wr.last = (row_pos == rows - 1) && (x == w - 1);
        has_wr  = 1'b1;
      end
    end
    byte_pos = byte_pos + 8'd1;
    if (byte_pos == 0 || byte_pos >= stride) begin
      byte_pos = '0;
      row_pos  = row_pos + 8'd1;
    end
    return has_wr;
  endfunction

  task automatic write_reg(input reg_index_t idx, input logic [SIZE_W-1:0] value);
    logic [APB_DATA_W-1:0] word;
    word = $urandom();
    word[SIZE_W-1:0] = value;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_WIDTH_QUADS:  width_cfg = word[SIZE_W-1:0];
      REG_HEIGHT_PAIRS: height_cfg = word[SIZE_W-1:0];
      REG_TOP_DOWN:     top_down_cfg = word[0];
      default: ;
    endcase
  endtask

  task automatic send_byte(input logic [PIX_W-1:0] pix, input bit start, input bit use_lit,
                           input frame_write_t lit, output bit taken);
    frame_write_t wr;
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid       <= 1'b1;
    pix_if.pixel_pair  <= pix;
    pix_if.image_start <= start;
    do @(posedge clk); while (!pix_if.ready);
    if (predict_write(pix, start, wr, taken)) pending_writes.push_back(use_lit ? lit : wr);
  endtask

  task automatic wait_idle();
    pix_if.valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    frame_write_t exp_wr;
    if (!rst && wr_if.valid && wr_if.ready) begin
      if (pending_writes.size() == 0) begin
        errors++;
        $display("%0t: no write expected, got address %0d data %0h last %0d", $time,
                 wr_if.write_address, wr_if.write_data, wr_if.last_of_image);
      end else begin
        exp_wr = pending_writes.pop_front();
        check_field("write_address", exp_wr.addr, wr_if.write_address);
        check_field("write_data", exp_wr.data, wr_if.write_data);
        check_field("last_of_image", exp_wr.last, wr_if.last_of_image);
      end
    end
  end

  // The long hold is armed by the stimulus and counted here, so the sender keeps
  // offering bytes while no transfer leaves the block.
  initial begin : result_sink
    int stall;
    wr_if.ready <= 1'b0;
    stall = 0;
    do @(posedge clk); while (rst);
    forever begin
      if (stall > 0) begin
        wr_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      wr_if.ready <= 1'b1;
      do @(posedge clk); while (!wr_if.valid);
      if (hold_armed) begin
        hold_armed = 1'b0;
        stall = LONG_HOLD;
      end else begin
        stall = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
      end
    end
  end

  initial begin : stimulus
    directed_step_t s;
    bit taken;
    int bytes_taken;
    int phase;
    int wq;
    int hpr;
    int td;
    int eff_w;
    int eff_h;
    int full;
    int len;
    rst                <= 1'b1;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    pix_if.valid       <= 1'b0;
    pix_if.pixel_pair  <= '0;
    pix_if.image_start <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_steps[i]) begin
      s = directed_steps[i];
      if (s.kind == STEP_REG) begin
        wait_idle();
        write_reg(s.idx, s.value);
      end else begin
        send_byte(s.pix, s.start, s.literal, s.wr, taken);
      end
    end

    bytes_taken = 0;
    phase = 0;
    while (bytes_taken < RANDOM_BYTES) begin
      wait_idle();
      if (phase == 0) begin
        wq = 127;
        hpr = 1;
        td = 0;
      end else if (phase == 2) begin
        wq = 8;
        hpr = 3;
        td = 1;
      end else begin
        case ($urandom_range(0, 15))
          0: wq = 0;
          1: wq = 1;
          2: wq = 127;
          3: wq = 80;
          default: wq = $urandom_range(1, 6);
        endcase
        case ($urandom_range(0, 15))
          0: hpr = 0;
          1: hpr = 1;
          2: hpr = 127;
          3: hpr = 100;
          default: hpr = $urandom_range(1, 3);
        endcase
        td = $urandom_range(0, 1);
      end
      write_reg(REG_WIDTH_QUADS, 7'(wq));
      write_reg(REG_HEIGHT_PAIRS, 7'(hpr));
      write_reg(REG_TOP_DOWN, 7'(td));
      eff_w = (wq == 0) ? 1 : wq;
      eff_h = (hpr == 0) ? 1 : hpr;
      full = 2 * eff_h * (((2 * eff_w + 3) / 4) * 4);
      tx_steady = (phase == 2) || ($urandom_range(0, 4) == 0);
      rx_steady = (phase != 2) && ($urandom_range(0, 4) == 0);
      if (phase == 2) hold_armed = 1'b1;

      repeat ($urandom_range(1, 3)) begin
        len = full;
        if (len > 700) len = $urandom_range(300, 700);
        else if ($urandom_range(0, 5) == 0) len = $urandom_range(1, len);
        for (int i = 0; i < len && bytes_taken < RANDOM_BYTES; i++) begin
          send_byte(8'($urandom_range(0, 255)), (i == 0) || ($urandom_range(0, 59) == 0),
                    1'b0, NO_WR, taken);
          if (taken) bytes_taken++;
        end
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 4)) begin
            send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, NO_WR, taken);
            if (taken) bytes_taken++;
          end
        end
        if ($urandom_range(0, 3) == 0) wait_idle();
      end
      phase++;
    end

    wait_idle();
    if (errors == 0) begin
      $display("tb_bmp4_to_cga_interlaced_packer: clean");
    end else begin
      $display("tb_bmp4_to_cga_interlaced_packer: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/bmpcga_pkg.sv
hw/rtl/bmpcga_if.sv
hw/rtl/bmp4_to_cga_interlaced_packer.sv
hw/rtl/bmpcga_checker.sv
dv/tb_bmp4_to_cga_interlaced_packer.sv
